// File: rtl/uv_sphere_vertex_generator_core_assert.svh
// ----------------------------------------------------------------------------
// uv sphere vertex generator assertion macros
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define UVS_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("uvs assertion failed");

// next-cycle implication
`define UVS_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("uvs assertion failed");

`endif

// File: rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// shared constants, types and arithmetic helpers of the uv sphere vertex core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uvs_pkg;

  localparam int MAX_SEGMENTS     = 1024;
  localparam int POS_FRAC_BITS    = 15;
  localparam int SEG_W            = 10;
  localparam int IDX_W            = 20;
  localparam int POS_W            = 16;
  localparam int CORDIC_FRAC      = 30;
  localparam int CORDIC_ITERS     = 30;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_ITERS / CORDIC_PER_STAGE;
  localparam int DIV_STEPS        = 33;
  localparam int DIV_PER_STAGE    = 3;
  localparam int DIV_STAGES       = DIV_STEPS / DIV_PER_STAGE;
  localparam int DEN_W            = SEG_W + 2;
  localparam int FIELD_SHIFT      = CORDIC_FRAC - POS_FRAC_BITS;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [63:0] FIELD_HI = (POS_FRAC_BITS >= POS_W - 1) ?
      64'sd32767 : (64'sd1 <<< POS_FRAC_BITS) - 64'sd1;
  localparam logic signed [63:0] FIELD_LO = (POS_FRAC_BITS >= POS_W - 1) ?
      -64'sd32768 : -(64'sd1 <<< POS_FRAC_BITS);

  localparam logic [1:0] REG_LAT = 2'd0;
  localparam logic [1:0] REG_LON = 2'd1;
  localparam logic [SEG_W-1:0] LAT_RESET = 10'd16;
  localparam logic [SEG_W-1:0] LON_RESET = 10'd32;

  typedef logic signed [31:0] cval_t;
  typedef logic signed [32:0] zval_t;

  typedef struct packed {
    logic             vvalid;
    logic             qvalid;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] ic;
    logic [IDX_W-1:0] id;
  } side_t;

  typedef struct packed {
    logic [SEG_W-1:0]     num;
    logic [DIV_STEPS-1:0] low;
    logic [DEN_W-1:0]     den;
    logic                 zero;
  } div_lane_t;

  function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_W-1:0] v);
    if (32'(v) > MAX_SEGMENTS - 1) return SEG_W'(MAX_SEGMENTS - 1);
    return v;
  endfunction

  function automatic logic [31:0] atan_turn(input int i);
    case (i)
      0:  return 32'h20000000;
      1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      15: return 32'h0000517D;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A30;
      19: return 32'h00000518;
      20: return 32'h0000028C;
      21: return 32'h00000146;
      22: return 32'h000000A3;
      23: return 32'h00000051;
      24: return 32'h00000029;
      25: return 32'h00000014;
      26: return 32'h0000000A;
      27: return 32'h00000005;
      28: return 32'h00000003;
      29: return 32'h00000001;
      default: return 32'h0;
    endcase
  endfunction

  // round to nearest, halves away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int s);
    logic [63:0] mag;
    if (s == 0) return v;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [POS_W-1:0] to_field(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = rnd_shift(v, FIELD_SHIFT);
    if (r > FIELD_HI) r = FIELD_HI;
    if (r < FIELD_LO) r = FIELD_LO;
    return r[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/uv_sphere_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_core
// unit-sphere vertex position and quad indices for one grid point per cycle
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  input   | in_valid / in_stall   | ring, column
//  output  | out_valid / out_stall | vertex_valid, pos_x/y/z, quad_valid,
//          |                       | index_a..index_d
//  config  | cfg_write             | cfg_index, cfg_data
//
//  one transaction per cycle sustained unless out_stall holds a waiting result;
//  the path is the input register, 12 divider stages (load plus 11 of 3
//  quotient bits), 17 cordic stages (load, 15 of 2 rotations, fold), then
//  3 stages of multiply, round and saturate.
//  rst is synchronous, clears valid bits and sets the segment registers to 16, 32.
//  out_stall with a result waiting freezes the whole pipeline; in_stall
//  follows it in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "uv_sphere_vertex_generator_core_assert.svh"

module uv_sphere_vertex_generator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [uvs_pkg::SEG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [uvs_pkg::SEG_W-1:0]    ring,
  input  logic [uvs_pkg::SEG_W-1:0]    column,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         vertex_valid,
  output logic [uvs_pkg::POS_W-1:0]    pos_x,
  output logic [uvs_pkg::POS_W-1:0]    pos_y,
  output logic [uvs_pkg::POS_W-1:0]    pos_z,
  output logic                         quad_valid,
  output logic [uvs_pkg::IDX_W-1:0]    index_a,
  output logic [uvs_pkg::IDX_W-1:0]    index_b,
  output logic [uvs_pkg::IDX_W-1:0]    index_c,
  output logic [uvs_pkg::IDX_W-1:0]    index_d
);
  import uvs_pkg::*;

  logic [SEG_W-1:0] lat_segments;
  logic [SEG_W-1:0] lon_segments;
  logic             adv;
  logic             v0;
  logic [SEG_W-1:0] ring0;
  logic [SEG_W-1:0] col0;
  logic [SEG_W-1:0] lat;
  logic [SEG_W-1:0] lon;
  logic [SEG_W:0]   lon1;
  logic [IDX_W:0]   a_full;
  logic [IDX_W:0]   c_full;
  side_t            side0;
  div_lane_t        lanes [2];

  logic             div_vld;
  logic [31:0]      phase [2];
  side_t            div_side;
  logic             cor_vld;
  cval_t            sn [2];
  cval_t            cs [2];
  side_t            cor_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_segments <= LAT_RESET;
      lon_segments <= LON_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LAT: lat_segments <= cfg_data;
        REG_LON: lon_segments <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
    if (adv) begin
      ring0 <= ring;
      col0  <= column;
    end
  end

  always_comb begin
    lat          = clamp_seg(lat_segments);
    lon          = clamp_seg(lon_segments);
    lon1         = {1'b0, lon} + 1'b1;
    a_full       = (IDX_W + 1)'(ring0) * (IDX_W + 1)'(lon1) + (IDX_W + 1)'(col0);
    c_full       = a_full + (IDX_W + 1)'(lon1);
    side0.vvalid = (ring0 <= lat) && (col0 <= lon);
    side0.qvalid = (ring0 < lat) && (col0 < lon);
    side0.ia     = side0.qvalid ? a_full[IDX_W-1:0] : '0;
    side0.ib     = side0.qvalid ? a_full[IDX_W-1:0] + 1'b1 : '0;
    side0.ic     = side0.qvalid ? c_full[IDX_W-1:0] : '0;
    side0.id     = side0.qvalid ? c_full[IDX_W-1:0] + 1'b1 : '0;

    // theta: (ring*2^33 + 2lat) / 4lat, phi: (column*2^33 + lon) / 2lon
    lanes[0].num  = ring0;
    lanes[0].low  = DIV_STEPS'({lat, 1'b0});
    lanes[0].den  = {lat, 2'b00};
    lanes[0].zero = (lat == '0);
    lanes[1].num  = col0;
    lanes[1].low  = DIV_STEPS'(lon);
    lanes[1].den  = DEN_W'({lon, 1'b0});
    lanes[1].zero = (lon == '0);
  end

  uvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (v0),
    .lane_in  (lanes),
    .side_in  (side0),
    .out_vld  (div_vld),
    .phase    (phase),
    .side_out (div_side)
  );

  uvs_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (div_vld),
    .phase    (phase),
    .side_in  (div_side),
    .out_vld  (cor_vld),
    .sn       (sn),
    .cs       (cs),
    .side_out (cor_side)
  );

  uvs_vout u_vout (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_vld       (cor_vld),
    .sin_t        (sn[0]),
    .cos_t        (cs[0]),
    .sin_p        (sn[1]),
    .cos_p        (cs[1]),
    .side_in      (cor_side),
    .out_vld      (out_valid),
    .vertex_valid (vertex_valid),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .quad_valid   (quad_valid),
    .index_a      (index_a),
    .index_b      (index_b),
    .index_c      (index_c),
    .index_d      (index_d)
  );

  `UVS_ASSERT_IMP(a_pos_zero, clk, rst, out_valid && !vertex_valid, (pos_x | pos_y | pos_z) == '0)
  `UVS_ASSERT_IMP(a_quad_in_vertex, clk, rst, out_valid && quad_valid, vertex_valid)
  `UVS_ASSERT_IMP(a_idx_b, clk, rst, out_valid && quad_valid, index_b == index_a + 20'd1)
  `UVS_ASSERT_IMP(a_idx_zero, clk, rst, out_valid && !quad_valid, (index_a | index_d) == '0)
  `UVS_ASSERT_NXT(a_hold_stall, clk, rst, out_valid && out_stall, in_stall || !out_stall)

endmodule

`default_nettype wire

// File: rtl/uvs_div.sv
// ----------------------------------------------------------------------------
// uvs_div
// pipelined restoring divider producing the theta and phi phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uvs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_vld,
  input  uvs_pkg::div_lane_t lane_in [2],
  input  uvs_pkg::side_t     side_in,
  output logic               out_vld,
  output logic [31:0]        phase [2],
  output uvs_pkg::side_t     side_out
);
  import uvs_pkg::*;

  logic                 vld  [DIV_STAGES+1];
  logic [DEN_W-1:0]     rem  [DIV_STAGES+1][2];
  logic [DIV_STEPS-1:0] quo  [DIV_STAGES+1][2];
  logic [DIV_STEPS-1:0] low  [DIV_STAGES+1][2];
  logic [DEN_W-1:0]     den  [DIV_STAGES+1][2];
  logic                 zero [DIV_STAGES+1][2];
  side_t                side [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
    end
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        rem[0][l]  <= DEN_W'(lane_in[l].num);
        quo[0][l]  <= '0;
        low[0][l]  <= lane_in[l].low;
        den[0][l]  <= lane_in[l].den;
        zero[0][l] <= lane_in[l].zero;
      end
      side[0] <= side_in;
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DEN_W-1:0]     r_n [2];
    logic [DIV_STEPS-1:0] q_n [2];
    logic [DIV_STEPS-1:0] l_n [2];

    always_comb begin
      logic [DEN_W:0] t;
      t = '0;
      for (int l = 0; l < 2; l++) begin
        r_n[l] = rem[g][l];
        q_n[l] = quo[g][l];
        l_n[l] = low[g][l];
        for (int k = 0; k < DIV_PER_STAGE; k++) begin
          t      = {r_n[l], l_n[l][DIV_STEPS-1]};
          l_n[l] = {l_n[l][DIV_STEPS-2:0], 1'b0};
          if (t >= {1'b0, den[g][l]}) begin
            t      = t - {1'b0, den[g][l]};
            q_n[l] = {q_n[l][DIV_STEPS-2:0], 1'b1};
          end else begin
            q_n[l] = {q_n[l][DIV_STEPS-2:0], 1'b0};
          end
          r_n[l] = t[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (adv) begin
        vld[g+1] <= vld[g];
      end
      if (adv) begin
        for (int l = 0; l < 2; l++) begin
          rem[g+1][l]  <= r_n[l];
          quo[g+1][l]  <= q_n[l];
          low[g+1][l]  <= l_n[l];
          den[g+1][l]  <= den[g][l];
          zero[g+1][l] <= zero[g][l];
        end
        side[g+1] <= side[g];
      end
    end
  end

  // zero segment count gives phase zero
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      phase[l] = zero[DIV_STAGES][l] ? 32'h0 : quo[DIV_STAGES][l][31:0];
    end
  end

  assign out_vld  = vld[DIV_STAGES];
  assign side_out = side[DIV_STAGES];

endmodule

`default_nettype wire

// File: rtl/uvs_cordic.sv
// ----------------------------------------------------------------------------
// uvs_cordic
// pipelined rotation-mode cordic, sine and cosine of two phases per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uvs_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [31:0]    phase [2],
  input  uvs_pkg::side_t side_in,
  output logic           out_vld,
  output uvs_pkg::cval_t sn [2],
  output uvs_pkg::cval_t cs [2],
  output uvs_pkg::side_t side_out
);
  import uvs_pkg::*;

  logic  vld  [CORDIC_STAGES+1];
  cval_t x    [CORDIC_STAGES+1][2];
  cval_t y    [CORDIC_STAGES+1][2];
  zval_t z    [CORDIC_STAGES+1][2];
  logic  flip [CORDIC_STAGES+1][2];
  side_t side [CORDIC_STAGES+1];

  logic  f_in  [2];
  zval_t z_in  [2];
  logic  o_vld;
  side_t o_side;

  // fold the phase into the right half plane
  always_comb begin
    logic [31:0] p;
    p = '0;
    for (int l = 0; l < 2; l++) begin
      p       = phase[l] + 32'h40000000;
      f_in[l] = p[31];
      p       = f_in[l] ? (phase[l] + 32'h80000000) : phase[l];
      z_in[l] = {p[31], p};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
    end
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        x[0][l]    <= CORDIC_GAIN;
        y[0][l]    <= '0;
        z[0][l]    <= z_in[l];
        flip[0][l] <= f_in[l];
      end
      side[0] <= side_in;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    cval_t xn [2];
    cval_t yn [2];
    zval_t zn [2];

    always_comb begin
      cval_t dx;
      cval_t dy;
      dx = '0;
      dy = '0;
      for (int l = 0; l < 2; l++) begin
        xn[l] = x[g][l];
        yn[l] = y[g][l];
        zn[l] = z[g][l];
        for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
          dx = yn[l] >>> (g * CORDIC_PER_STAGE + j);
          dy = xn[l] >>> (g * CORDIC_PER_STAGE + j);
          if (!zn[l][32]) begin
            xn[l] = xn[l] - dx;
            yn[l] = yn[l] + dy;
            zn[l] = zn[l] - $signed({1'b0, atan_turn(g * CORDIC_PER_STAGE + j)});
          end else begin
            xn[l] = xn[l] + dx;
            yn[l] = yn[l] - dy;
            zn[l] = zn[l] + $signed({1'b0, atan_turn(g * CORDIC_PER_STAGE + j)});
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (adv) begin
        vld[g+1] <= vld[g];
      end
      if (adv) begin
        for (int l = 0; l < 2; l++) begin
          x[g+1][l]    <= xn[l];
          y[g+1][l]    <= yn[l];
          z[g+1][l]    <= zn[l];
          flip[g+1][l] <= flip[g][l];
        end
        side[g+1] <= side[g];
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= vld[CORDIC_STAGES];
    end
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        sn[l] <= flip[CORDIC_STAGES][l] ? -y[CORDIC_STAGES][l] : y[CORDIC_STAGES][l];
        cs[l] <= flip[CORDIC_STAGES][l] ? -x[CORDIC_STAGES][l] : x[CORDIC_STAGES][l];
      end
      o_side <= side[CORDIC_STAGES];
    end
  end

  assign out_vld  = o_vld;
  assign side_out = o_side;

endmodule

`default_nettype wire

// File: rtl/uvs_vout.sv
// ----------------------------------------------------------------------------
// uvs_vout
// position products, rounding, saturation and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uvs_vout (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_vld,
  input  uvs_pkg::cval_t               sin_t,
  input  uvs_pkg::cval_t               cos_t,
  input  uvs_pkg::cval_t               sin_p,
  input  uvs_pkg::cval_t               cos_p,
  input  uvs_pkg::side_t               side_in,
  output logic                         out_vld,
  output logic                         vertex_valid,
  output logic [uvs_pkg::POS_W-1:0]    pos_x,
  output logic [uvs_pkg::POS_W-1:0]    pos_y,
  output logic [uvs_pkg::POS_W-1:0]    pos_z,
  output logic                         quad_valid,
  output logic [uvs_pkg::IDX_W-1:0]    index_a,
  output logic [uvs_pkg::IDX_W-1:0]    index_b,
  output logic [uvs_pkg::IDX_W-1:0]    index_c,
  output logic [uvs_pkg::IDX_W-1:0]    index_d
);
  import uvs_pkg::*;

  logic               v1;
  logic               v2;
  logic signed [63:0] px;
  logic signed [63:0] pz;
  cval_t              cy1;
  cval_t              cy2;
  logic signed [33:0] rx;
  logic signed [33:0] rz;
  side_t              s1;
  side_t              s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      v1      <= in_vld;
      v2      <= v1;
      out_vld <= v2;
    end
    if (adv) begin
      px  <= sin_t * cos_p;
      pz  <= sin_t * sin_p;
      cy1 <= cos_t;
      s1  <= side_in;

      rx  <= 34'(rnd_shift(px, CORDIC_FRAC));
      rz  <= 34'(rnd_shift(pz, CORDIC_FRAC));
      cy2 <= cy1;
      s2  <= s1;

      vertex_valid <= s2.vvalid;
      pos_x        <= s2.vvalid ? to_field(64'(rx)) : '0;
      pos_y        <= s2.vvalid ? to_field(64'(cy2)) : '0;
      pos_z        <= s2.vvalid ? to_field(64'(rz)) : '0;
      quad_valid   <= s2.qvalid;
      index_a      <= s2.ia;
      index_b      <= s2.ib;
      index_c      <= s2.ic;
      index_d      <= s2.id;
    end
  end

endmodule

`default_nettype wire
